FILE: hdl/hbd_pkg.sv
package hbd_pkg;

    // Field widths of the stream items.
    localparam int CODE_W    = 24;
    localparam int LEN_W     = 5;
    localparam int SYM_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 4;

    // Longest code the table may hold; the accumulator width caps it.
    localparam int MAX_CODE_LEN = 24;
    localparam int USE_LEN      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // Input request kinds.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    // Configuration space: register index is paddr[2].
    localparam int   PADDR_W      = 3;
    localparam int   PDATA_W      = 32;
    localparam logic REG_PAD_BITS = 1'b0;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [SYM_W-1:0]  symbol_value;
        logic [BYTE_W-1:0] data_byte;
        logic              final_byte;
    } t_hbd_in;

    typedef struct packed {
        logic [SYM_W-1:0] symbol_out;
        logic             code_overflow;
        logic             run_last;
    } t_hbd_out;

    // One stored code table entry.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
        logic [SYM_W-1:0]  sym;
    } t_hbd_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_start;
        logic tbl_write;
        logic shift;
        logic res_latch;
        logic res_push;
        logic acc_clear;
        logic flush;
    } t_hbd_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic load_ok;
        logic scan_done;
        logic scan_hit;
        logic acc_full;
        logic table_full;
        logic out_free;
        logic pend_valid;
        logic bit_last;
        logic item_final;
    } t_hbd_stat;

endpackage

FILE: hdl/hbd_datapath.sv
module hbd_datapath import hbd_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_hbd_cmd         i_cmd,
    output t_hbd_stat        o_stat,
    input  t_hbd_in          i_item,
    input  logic [2:0]       i_pad_bits,
    output logic             o_valid,
    output t_hbd_out         o_data,
    input  logic             i_stall
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);

    // Captured request.
    logic              r_mode;
    logic              r_final;
    logic [BYTE_W-1:0] r_byte;
    logic [CNT_W-1:0]  r_left;
    logic [CODE_W-1:0] r_ld_bits;
    logic [LEN_W-1:0]  r_ld_len;
    logic [SYM_W-1:0]  r_ld_sym;

    // Code accumulator and table.
    logic [CODE_W-1:0] r_acc_bits;
    logic [LEN_W-1:0]  r_acc_len;
    logic [FW-1:0]     r_fill;
    t_hbd_entry        r_mem [ENTRIES];

    // Table scan engine.
    logic              r_scan_act;
    logic [FW-1:0]     r_scan_idx;
    logic              r_cmp_v;
    t_hbd_entry        r_rd;

    // Result staging: latched result, pending result, output register.
    logic [SYM_W-1:0]  r_res_sym;
    logic              r_res_ovf;
    logic              r_pend_v;
    logic [SYM_W-1:0]  r_pend_sym;
    logic              r_pend_ovf;
    logic              r_out_valid;
    t_hbd_out          r_out;

    logic [CODE_W-1:0] key_bits;
    logic [LEN_W-1:0]  key_len;
    logic [CODE_W-1:0] ld_mask;
    logic              issue;
    logic              hit;
    logic              done;
    logic              out_free;

    // Search key: the accumulator for data, the new code for a load.
    assign key_bits = (r_mode == MODE_DATA) ? r_acc_bits : r_ld_bits;
    assign key_len  = (r_mode == MODE_DATA) ? r_acc_len  : r_ld_len;
    assign ld_mask  = ~({CODE_W{1'b1}} << i_item.code_length);

    // One table entry is read per cycle and compared the cycle after.
    assign issue    = r_scan_act && (r_scan_idx < r_fill);
    assign hit      = r_scan_act && r_cmp_v && (r_rd.len == key_len) && (r_rd.bits == key_bits);
    assign done     = r_scan_act && (hit || (!r_cmp_v && !issue));
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        o_stat.load_ok    = (r_ld_len != '0) && (r_ld_len <= LEN_W'(USE_LEN));
        o_stat.scan_done  = done;
        o_stat.scan_hit   = hit;
        o_stat.acc_full   = (r_acc_len >= LEN_W'(USE_LEN));
        o_stat.table_full = (r_fill == FW'(ENTRIES));
        o_stat.out_free   = out_free;
        o_stat.pend_valid = r_pend_v;
        o_stat.bit_last   = (r_left == '0);
        o_stat.item_final = r_final;
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_item.mode;
            r_final   <= i_item.final_byte;
            r_ld_bits <= i_item.code_bits & ld_mask;
            r_ld_len  <= i_item.code_length;
            r_ld_sym  <= i_item.symbol_value;
            r_byte    <= i_item.data_byte;
            r_left    <= i_item.final_byte ? (CNT_W'(BYTE_W) - CNT_W'(i_pad_bits))
                                           : CNT_W'(BYTE_W);
        end else if (i_cmd.shift) begin
            r_byte <= {r_byte[BYTE_W-2:0], 1'b0};
            r_left <= r_left - 1'b1;
        end
    end

    // Accumulator: a bit enters at the bottom, a result or end of stream clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_bits <= '0;
            r_acc_len  <= '0;
        end else if (i_cmd.res_push || i_cmd.acc_clear) begin
            r_acc_bits <= '0;
            r_acc_len  <= '0;
        end else if (i_cmd.shift) begin
            r_acc_bits <= {r_acc_bits[CODE_W-2:0], r_byte[BYTE_W-1]};
            r_acc_len  <= r_acc_len + 1'b1;
        end
    end

    // Table memory: written at the fill position, read by the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_write) begin
            r_mem[r_fill[AW-1:0]] <= '{len: r_ld_len, bits: r_ld_bits, sym: r_ld_sym};
        end
        if (issue) begin
            r_rd <= r_mem[r_scan_idx[AW-1:0]];
        end
    end

    // Fill count marks which entries hold codes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.tbl_write) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // Scan sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_act <= 1'b0;
            r_scan_idx <= '0;
            r_cmp_v    <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_scan_act <= 1'b1;
            r_scan_idx <= '0;
            r_cmp_v    <= 1'b0;
        end else if (done) begin
            r_scan_act <= 1'b0;
            r_cmp_v    <= 1'b0;
        end else begin
            r_cmp_v <= issue;
            if (issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
        end
    end

    // Latch the outcome of a finished scan as a result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_latch) begin
            r_res_sym <= hit ? r_rd.sym : '0;
            r_res_ovf <= !hit;
        end
    end

    // Pending result waits until it is known whether it is the last of its byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (i_cmd.res_push) begin
            r_pend_v   <= 1'b1;
            r_pend_sym <= r_res_sym;
            r_pend_ovf <= r_res_ovf;
        end else if (i_cmd.flush) begin
            r_pend_v <= 1'b0;
        end
    end

    // Output register: loaded from the pending result, emptied when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.res_push && r_pend_v) || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.res_push && r_pend_v) || i_cmd.flush) begin
            r_out.symbol_out    <= r_pend_sym;
            r_out.code_overflow <= r_pend_ovf;
            r_out.run_last      <= i_cmd.flush;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: hdl/hbd_ctrl.sv
module hbd_ctrl import hbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_mode,
    input  t_hbd_stat i_stat,
    output logic      o_busy,
    output t_hbd_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_LSCAN,
        S_SHIFT,
        S_DSCAN,
        S_RESULT,
        S_NEXT,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_mode == MODE_DATA) ? S_SHIFT : S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.load_ok) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_LSCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LSCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.tbl_write = !i_stat.scan_hit && !i_stat.table_full;
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                o_cmd.shift      = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state = S_DSCAN;
            end
            S_DSCAN: begin
                if (i_stat.scan_done) begin
                    if (i_stat.scan_hit || i_stat.acc_full) begin
                        o_cmd.res_latch = 1'b1;
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_RESULT: begin
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.res_push = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_stat.bit_last) begin
                    o_cmd.acc_clear = i_stat.item_final;
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: hdl/huffman_bitstream_decoder_top.sv
// Huffman decoder with a loadable code table of TABLE_ENTRIES entries. A request with mode 0
// adds a code (ignored when its length is zero or too long, when the code is already present,
// or when the table is full); a request with mode 1 decodes one byte, most significant bit
// first, and gives one result per completed code or per code that overran the maximum length,
// with run_last set on the final result of that byte. One request is worked on at a time.
// Each decoded bit searches the table through its single read port, one entry per cycle, and a
// load searches it the same way for a duplicate; stalls on the output hold up a bit that gives
// a result and the end of each byte. The table is empty after reset through its fill count, so
// no clearing pass is needed.
module huffman_bitstream_decoder_top import hbd_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_hbd_in            i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output t_hbd_out           o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic       pad_sel;
    logic [2:0] r_pad;
    t_hbd_cmd   cmd;
    t_hbd_stat  stat;
    logic       busy;

    // Padding register, written through the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_PAD_BITS)) begin
            r_pad <= pwdata[2:0];
        end
    end

    assign pad_sel = (paddr[2] == REG_PAD_BITS);
    assign prdata  = pad_sel ? {{(PDATA_W-3){1'b0}}, r_pad} : '0;
    assign pready  = 1'b1;
    assign o_stall = busy;

    hbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_data.mode),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    hbd_datapath #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_item     (i_data),
        .i_pad_bits (r_pad),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

endmodule
